// ----- design/cpsl_pkg.sv -----
// Shared types, constants and ChaCha helper functions for the ChaCha20-Poly1305 seal block.
package cpsl_pkg;

  localparam logic [1:0] OP_AAD  = 2'd0;
  localparam logic [1:0] OP_TEXT = 2'd1;
  localparam logic [1:0] OP_FIN  = 2'd2;

  localparam logic [2:0] REG_KEY0     = 3'd0;
  localparam logic [2:0] REG_KEY1     = 3'd1;
  localparam logic [2:0] REG_KEY2     = 3'd2;
  localparam logic [2:0] REG_KEY3     = 3'd3;
  localparam logic [2:0] REG_NONCE_LO = 3'd4;
  localparam logic [2:0] REG_NONCE_HI = 3'd5;

  localparam int QDEPTH = 4;
  localparam int QW     = $clog2(QDEPTH);

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam logic [25:0] MASK26 = 26'h3ffffff;
  localparam logic [25:0] CLAMP1 = 26'h3ffff03;
  localparam logic [25:0] CLAMP2 = 26'h3ffc0ff;
  localparam logic [25:0] CLAMP3 = 26'h3f03fff;
  localparam logic [25:0] CLAMP4 = 26'h00fffff;
  localparam logic [31:0] LIMB_TOP = 32'h4000000;

  typedef enum logic [1:0] {
    CMD_AAD  = 2'd0,
    CMD_TEXT = 2'd1,
    CMD_FIN  = 2'd2,
    CMD_ERR  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [63:0] data;
    logic [3:0]  n;
  } cmd_t;

  typedef struct packed {
    logic        start;
    logic [31:0] ctr;
  } cc_req_t;

  typedef struct packed {
    logic blk;
    logic tag;
    logic clear;
    logic key;
  } poly_req_t;

  typedef enum logic [2:0] {
    P_IDLE, P_MUL, P_CARRY, P_FIX, P_TC, P_TG, P_TA
  } poly_state_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_KEYW, S_ROUTE, S_BYTE, S_KSW, S_PW,
    S_OUT, S_LENS, S_TAG, S_TW, S_T1, S_T2
  } back_state_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [127:0] qr(input logic [31:0] a_i, input logic [31:0] b_i,
                                      input logic [31:0] c_i, input logic [31:0] d_i);
    logic [31:0] a, b, c, d;
    a = a_i; b = b_i; c = c_i; d = d_i;
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    return {a, b, c, d};
  endfunction

endpackage

// ----- design/cpsl_if.sv -----
// Valid/ready channel interfaces for the input items and the result items.
interface cpsl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  modport source(output valid, opcode, data_word, byte_count, input ready);
  modport sink(input valid, opcode, data_word, byte_count, output ready);
endinterface

interface cpsl_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_out;
  logic        out_kind;
  logic [3:0]  out_bytes;
  logic        last_of_run;
  logic        order_error;
  modport source(output valid, data_out, out_kind, out_bytes, last_of_run, order_error,
                 input ready);
  modport sink(input valid, data_out, out_kind, out_bytes, last_of_run, order_error,
               output ready);
endinterface

// ----- design/chacha20_poly1305_seal.sv -----
// Top level of the ChaCha20-Poly1305 seal block: configuration registers and unit wiring.
//
// The block seals a message given as a stream of items on in_ch: aad chunks, plaintext
// chunks of up to eight bytes, and a finish item. Ciphertext chunks and the two 64-bit
// tag words leave on out_ch, in order. The user must write the key and nonce through the
// cfg_ port, one register per write, while the block is idle; the block does not check.
// A front end classifies each item and puts it into a four-entry command queue; in_ch is
// ready whenever that queue has room, so items keep flowing while a result waits.
// The back end walks the chunk one byte per cycle, pausing while a keystream block or a
// MAC block is computed. Keystream blocks come from an iterative ChaCha unit, needed
// on the first chunk of a message (the Poly1305 key) and once every 64 plaintext bytes.
// Each full 16-byte MAC block passes through the five-lane Poly1305 unit. A finish item
// costs up to two MAC blocks, a tag pass and two output results. Sustained throughput
// is set by the byte-serial absorb loop and the Poly1305 unit.
// A single output register holds each result; when the receiver stalls the back end
// waits on it, and once the queue fills in_ch drops ready.
// Synchronous reset clears the message state, the sticky order_error flag and the
// key and nonce registers (to zero).
module chacha20_poly1305_seal import cpsl_pkg::*; #(
  parameter int CHUNK_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  cpsl_in_if.sink     in_ch,
  cpsl_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [63:0]  key_r [4];
  logic [63:0]  nonce_lo_r;
  logic [31:0]  nonce_hi_r;

  logic         cmd_valid, pop;
  cmd_t         cmd;
  cc_req_t      cc_req;
  logic         cc_done;
  logic [511:0] blk;
  poly_req_t    poly_req;
  logic [127:0] poly_m, tag;
  logic         poly_done;

  // Register writes; indexes past the nonce are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      nonce_lo_r <= '0;
      nonce_hi_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY0:     key_r[0]   <= cfg_wdata;
        REG_KEY1:     key_r[1]   <= cfg_wdata;
        REG_KEY2:     key_r[2]   <= cfg_wdata;
        REG_KEY3:     key_r[3]   <= cfg_wdata;
        REG_NONCE_LO: nonce_lo_r <= cfg_wdata;
        REG_NONCE_HI: nonce_hi_r <= cfg_wdata[31:0];
        default:      nonce_hi_r <= nonce_hi_r;
      endcase
    end
  end

  cpsl_front #(.CHUNK_BYTES(CHUNK_BYTES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .pop       (pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  cpsl_chacha u_chacha (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cc_req),
    .key   ({key_r[3], key_r[2], key_r[1], key_r[0]}),
    .nonce ({nonce_hi_r, nonce_lo_r}),
    .done  (cc_done),
    .blk   (blk)
  );

  // The Poly1305 key is the first 32 bytes of keystream block zero.
  cpsl_poly u_poly (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (poly_req),
    .m       (poly_m),
    .key_blk (blk[255:0]),
    .done    (poly_done),
    .tag     (tag)
  );

  cpsl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop),
    .cc_req    (cc_req),
    .cc_done   (cc_done),
    .blk       (blk),
    .poly_req  (poly_req),
    .poly_m    (poly_m),
    .poly_done (poly_done),
    .tag       (tag),
    .out_ch    (out_ch)
  );

  // The back end never pops an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cmd_valid)
    else $error("command queue popped while empty");

  // A ciphertext result always closes its run and carries at least one byte.
  a_ct_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.out_kind) |-> (out_ch.last_of_run && out_ch.out_bytes != 4'd0))
    else $error("malformed ciphertext result");

  // The second tag word follows the first one right after it is taken.
  a_tag_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.out_kind && !out_ch.last_of_run) |=>
    (out_ch.valid && out_ch.out_kind && out_ch.last_of_run))
    else $error("second tag word missing");

endmodule

// ----- design/cpsl_front.sv -----
// Front end: accepts items, classifies them into commands and queues them for the back end.
module cpsl_front import cpsl_pkg::*; #(
  parameter int CHUNK_BYTES = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  cpsl_in_if.sink  in_ch,
  input  logic     pop,
  output logic     cmd_valid,
  output cmd_t     cmd
);

  localparam logic [3:0] CHUNK_N = 4'(CHUNK_BYTES);

  cmd_t          q_r [QDEPTH];
  logic [QW-1:0] wp_r, rp_r;
  logic [QW:0]   cnt_r;
  logic          phase_r;
  logic          accept, push, do_pop;
  logic [3:0]    n;
  cmd_t          new_cmd;

  assign in_ch.ready = (cnt_r != (QW+1)'(QDEPTH));
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != '0);
  assign cmd         = q_r[rp_r];
  assign do_pop      = pop && cmd_valid;

  always_comb begin
    n = (in_ch.byte_count > CHUNK_N) ? CHUNK_N : in_ch.byte_count;
    new_cmd.data = in_ch.data_word;
    new_cmd.n    = n;
    new_cmd.kind = CMD_AAD;
    push = 1'b0;
    case (in_ch.opcode)
      OP_AAD: begin
        // An aad chunk after plaintext is dropped; the back end raises the flag in order.
        if (phase_r) begin
          new_cmd.kind = CMD_ERR;
          push = 1'b1;
        end else begin
          push = (n != 4'd0);
        end
      end
      OP_TEXT: begin
        new_cmd.kind = CMD_TEXT;
        push = (n != 4'd0);
      end
      OP_FIN: begin
        new_cmd.kind = CMD_FIN;
        push = 1'b1;
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      cnt_r   <= '0;
      phase_r <= 1'b0;
    end else begin
      if (accept && push) begin
        q_r[wp_r] <= new_cmd;
        wp_r      <= wp_r + 1'b1;
      end
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QW+1)'(accept && push) - (QW+1)'(do_pop);
      if (accept && push) begin
        if (new_cmd.kind == CMD_TEXT) phase_r <= 1'b1;
        else if (new_cmd.kind == CMD_FIN) phase_r <= 1'b0;
      end
    end
  end

endmodule

// ----- design/cpsl_chacha.sv -----
// Iterative ChaCha20 block unit: four quarter rounds per cycle, twenty rounds.
module cpsl_chacha import cpsl_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  cc_req_t       req,
  input  logic [255:0]  key,
  input  logic [95:0]   nonce,
  output logic          done,
  output logic [511:0]  blk
);

  logic [31:0]  x_r [16];
  logic [31:0]  x_nxt [16];
  logic [31:0]  init_r [16];
  logic [31:0]  init_w [16];
  logic [4:0]   rnd_r;
  logic         run_r, fin_r, done_r;
  logic [511:0] blk_r;

  assign done = done_r;
  assign blk  = blk_r;

  always_comb begin
    init_w[0]  = SIGMA0;
    init_w[1]  = SIGMA1;
    init_w[2]  = SIGMA2;
    init_w[3]  = SIGMA3;
    for (int k = 0; k < 8; k++) init_w[4 + k] = key[32*k +: 32];
    init_w[12] = req.ctr;
    init_w[13] = nonce[31:0];
    init_w[14] = nonce[63:32];
    init_w[15] = nonce[95:64];
  end

  // Even rounds work on columns, odd rounds on diagonals.
  always_comb begin
    logic [1:0]   q, o;
    logic [3:0]   ia, ib, ic, id;
    logic [127:0] res;
    x_nxt = x_r;
    o = rnd_r[0] ? 2'd1 : 2'd0;
    for (int k = 0; k < 4; k++) begin
      q  = 2'(k);
      ia = {2'd0, q};
      ib = {2'd1, q + o};
      ic = {2'd2, q + o + o};
      id = {2'd3, q + o + o + o};
      res = qr(x_r[ia], x_r[ib], x_r[ic], x_r[id]);
      x_nxt[ia] = res[127:96];
      x_nxt[ib] = res[95:64];
      x_nxt[ic] = res[63:32];
      x_nxt[id] = res[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        rnd_r <= '0;
      end else if (run_r) begin
        rnd_r <= rnd_r + 5'd1;
        if (rnd_r == 5'd19) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      init_r <= init_w;
      x_r    <= init_w;
    end else if (run_r) begin
      x_r <= x_nxt;
    end
    if (fin_r) begin
      for (int i = 0; i < 16; i++) blk_r[32*i +: 32] <= x_r[i] + init_r[i];
    end
  end

endmodule

// ----- design/cpsl_poly.sv -----
// Poly1305 unit: five-lane multiply, serial carry, and tag finalization.
module cpsl_poly import cpsl_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  poly_req_t     req,
  input  logic [127:0]  m,
  input  logic [255:0]  key_blk,
  output logic          done,
  output logic [127:0]  tag
);

  logic [25:0]  r_r [5];
  logic [127:0] pad_r;
  logic [26:0]  h_r [5];
  logic [27:0]  hm_r [5];
  logic [28:0]  coef_r [5];
  logic [56:0]  prod_r [5];
  logic [59:0]  d_r [5];
  logic [31:0]  c_r;
  logic [2:0]   step_r;
  logic         done_r;
  logic [127:0] pack_r, tag_r;
  poly_state_t  st_r, st_nxt;
  logic [25:0]  mlimb [5];
  logic [31:0]  tc_h [5];
  logic [127:0] tg_pack;
  logic [31:0]  fix_t0;
  logic [31:0]  cc;

  assign done = done_r;
  assign tag  = tag_r;

  assign mlimb[0] = m[25:0];
  assign mlimb[1] = m[51:26];
  assign mlimb[2] = m[77:52];
  assign mlimb[3] = m[103:78];
  assign mlimb[4] = {1'b0, 1'b1, m[127:104]};

  assign cc     = d_r[0][57:26];
  assign fix_t0 = {5'd0, h_r[0]} + {c_r[29:0], 2'b00} + c_r;

  // Final carry pass over the accumulator.
  always_comb begin
    logic [31:0] h0, h1, h2, h3, h4, c;
    h0 = {5'd0, h_r[0]}; h1 = {5'd0, h_r[1]}; h2 = {5'd0, h_r[2]};
    h3 = {5'd0, h_r[3]}; h4 = {5'd0, h_r[4]};
    c = h1 >> 26; h1 = h1 & {6'd0, MASK26}; h2 = h2 + c;
    c = h2 >> 26; h2 = h2 & {6'd0, MASK26}; h3 = h3 + c;
    c = h3 >> 26; h3 = h3 & {6'd0, MASK26}; h4 = h4 + c;
    c = h4 >> 26; h4 = h4 & {6'd0, MASK26}; h0 = h0 + {c[29:0], 2'b00} + c;
    c = h0 >> 26; h0 = h0 & {6'd0, MASK26}; h1 = h1 + c;
    tc_h[0] = h0; tc_h[1] = h1; tc_h[2] = h2; tc_h[3] = h3; tc_h[4] = h4;
  end

  // Conditional subtraction of p and packing into four words.
  always_comb begin
    logic [31:0] h0, h1, h2, h3, h4, g0, g1, g2, g3, g4, c, mask;
    h0 = {5'd0, h_r[0]}; h1 = {5'd0, h_r[1]}; h2 = {5'd0, h_r[2]};
    h3 = {5'd0, h_r[3]}; h4 = {5'd0, h_r[4]};
    g0 = h0 + 32'd5; c = g0 >> 26; g0 = g0 & {6'd0, MASK26};
    g1 = h1 + c;     c = g1 >> 26; g1 = g1 & {6'd0, MASK26};
    g2 = h2 + c;     c = g2 >> 26; g2 = g2 & {6'd0, MASK26};
    g3 = h3 + c;     c = g3 >> 26; g3 = g3 & {6'd0, MASK26};
    g4 = h4 + c - LIMB_TOP;
    mask = {32{~g4[31]}};
    h0 = (h0 & ~mask) | (g0 & mask);
    h1 = (h1 & ~mask) | (g1 & mask);
    h2 = (h2 & ~mask) | (g2 & mask);
    h3 = (h3 & ~mask) | (g3 & mask);
    h4 = (h4 & ~mask) | (g4 & mask);
    tg_pack = {(h3 >> 18) | (h4 << 8), (h2 >> 12) | (h3 << 14),
               (h1 >> 6) | (h2 << 20), h0 | (h1 << 26)};
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      P_IDLE: begin
        if (req.blk) st_nxt = P_MUL;
        else if (req.tag) st_nxt = P_TC;
      end
      P_MUL:   if (step_r == 3'd5) st_nxt = P_CARRY;
      P_CARRY: if (step_r == 3'd4) st_nxt = P_FIX;
      P_FIX:   st_nxt = P_IDLE;
      P_TC:    st_nxt = P_TG;
      P_TG:    st_nxt = P_TA;
      P_TA:    st_nxt = P_IDLE;
      default: st_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= P_IDLE;
      done_r <= 1'b0;
      step_r <= '0;
      for (int i = 0; i < 5; i++) h_r[i] <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == P_FIX) || (st_r == P_TA);
      case (st_r)
        P_IDLE: begin
          step_r <= '0;
          if (req.blk) begin
            for (int i = 0; i < 5; i++) begin
              hm_r[i]   <= {1'b0, h_r[i]} + {2'b00, mlimb[i]};
              coef_r[i] <= {3'b000, r_r[i]};
              d_r[i]    <= '0;
            end
          end
          if (req.clear) begin
            for (int i = 0; i < 5; i++) h_r[i] <= '0;
          end
          if (req.key) begin
            r_r[0] <= key_blk[25:0] & MASK26;
            r_r[1] <= key_blk[51:26] & CLAMP1;
            r_r[2] <= key_blk[77:52] & CLAMP2;
            r_r[3] <= key_blk[103:78] & CLAMP3;
            r_r[4] <= {2'b00, key_blk[127:104]} & CLAMP4;
            pad_r  <= key_blk[255:128];
          end
        end
        P_MUL: begin
          // Lane k forms d_k; h limbs shift past the lanes, coefficients rotate.
          for (int k = 0; k < 5; k++) begin
            prod_r[k] <= hm_r[0] * coef_r[k];
            if (step_r != 3'd0) d_r[k] <= d_r[k] + {3'b000, prod_r[k]};
          end
          for (int i = 0; i < 4; i++) hm_r[i] <= hm_r[i+1];
          hm_r[4]   <= '0;
          coef_r[0] <= {coef_r[4][26:0], 2'b00} + coef_r[4];
          for (int k = 1; k < 5; k++) coef_r[k] <= coef_r[k-1];
          step_r <= (step_r == 3'd5) ? 3'd0 : step_r + 3'd1;
        end
        P_CARRY: begin
          for (int i = 0; i < 4; i++) h_r[i] <= h_r[i+1];
          h_r[4] <= {1'b0, d_r[0][25:0]};
          d_r[0] <= d_r[1] + {28'd0, cc};
          for (int i = 1; i < 4; i++) d_r[i] <= d_r[i+1];
          c_r    <= cc;
          step_r <= step_r + 3'd1;
        end
        P_FIX: begin
          h_r[0] <= {1'b0, fix_t0[25:0]};
          h_r[1] <= h_r[1] + {21'd0, fix_t0[31:26]};
        end
        P_TC: begin
          for (int i = 0; i < 5; i++) h_r[i] <= tc_h[i][26:0];
        end
        P_TG: pack_r <= tg_pack;
        P_TA: tag_r  <= pack_r + pad_r;
        default: step_r <= '0;
      endcase
    end
  end

endmodule

// ----- design/cpsl_back.sv -----
// Back end: sequences commands over the ChaCha and Poly1305 units and holds the result register.
module cpsl_back import cpsl_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  cmd_t          cmd,
  output logic          pop,
  output cc_req_t       cc_req,
  input  logic          cc_done,
  input  logic [511:0]  blk,
  output poly_req_t     poly_req,
  output logic [127:0]  poly_m,
  input  logic          poly_done,
  input  logic [127:0]  tag,
  cpsl_out_if.source    out_ch
);

  back_state_t  st_r, st_nxt, ret_r;
  cmd_t         cmd_r;
  logic [3:0]   i_r, fill_r;
  logic [6:0]   used_r;
  logic [31:0]  ctr_r;
  logic [127:0] buf_r, buf_w;
  logic [63:0]  aad_tot_r, txt_tot_r, ct_r;
  logic         phase_r, keyrdy_r, err_r;
  logic         ov_r, okind_r, olast_r, oerr_r;
  logic [63:0]  odata_r;
  logic [3:0]   obytes_r;
  logic         out_free, load_out, is_text, need_ks, bytes_left;
  logic [7:0]   cur_byte, ks_byte, b;

  assign out_ch.valid       = ov_r;
  assign out_ch.data_out    = odata_r;
  assign out_ch.out_kind    = okind_r;
  assign out_ch.out_bytes   = obytes_r;
  assign out_ch.last_of_run = olast_r;
  assign out_ch.order_error = oerr_r;

  assign out_free   = !ov_r || out_ch.ready;
  assign load_out   = out_free && (st_r == S_OUT || st_r == S_T1 || st_r == S_T2);
  assign is_text    = (cmd_r.kind == CMD_TEXT);
  assign need_ks    = is_text && used_r[6];
  assign bytes_left = (i_r != cmd_r.n);
  assign cur_byte   = cmd_r.data[{i_r[2:0], 3'b000} +: 8];
  assign ks_byte    = blk[{used_r[5:0], 3'b000} +: 8];
  assign b          = cur_byte ^ (is_text ? ks_byte : 8'h00);

  always_comb begin
    buf_w = buf_r;
    buf_w[{fill_r, 3'b000} +: 8] = b;
  end

  always_comb begin
    st_nxt   = st_r;
    pop      = 1'b0;
    cc_req   = '{start: 1'b0, ctr: ctr_r};
    poly_req = '0;
    poly_m   = buf_r;
    case (st_r)
      S_IDLE: begin
        if (cmd_valid) begin
          pop    = 1'b1;
          st_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (cmd_r.kind == CMD_ERR) begin
          st_nxt = S_IDLE;
        end else if (!keyrdy_r) begin
          cc_req = '{start: 1'b1, ctr: 32'd0};
          st_nxt = S_KEYW;
        end else begin
          st_nxt = S_ROUTE;
        end
      end
      S_KEYW: begin
        if (cc_done) begin
          poly_req.key = 1'b1;
          st_nxt = S_ROUTE;
        end
      end
      S_ROUTE: begin
        case (cmd_r.kind)
          CMD_AAD: st_nxt = S_BYTE;
          CMD_TEXT: begin
            if (!phase_r && fill_r != 4'd0) begin
              poly_req.blk = 1'b1;
              st_nxt = S_PW;
            end else begin
              st_nxt = S_BYTE;
            end
          end
          CMD_FIN: begin
            if (fill_r != 4'd0) begin
              poly_req.blk = 1'b1;
              st_nxt = S_PW;
            end else begin
              st_nxt = S_LENS;
            end
          end
          default: st_nxt = S_IDLE;
        endcase
      end
      S_BYTE: begin
        if (!bytes_left) begin
          st_nxt = is_text ? S_OUT : S_IDLE;
        end else if (need_ks) begin
          cc_req.start = 1'b1;
          st_nxt = S_KSW;
        end else if (fill_r == 4'd15) begin
          poly_req.blk = 1'b1;
          poly_m = buf_w;
          st_nxt = S_PW;
        end
      end
      S_KSW:  if (cc_done) st_nxt = S_BYTE;
      S_PW:   if (poly_done) st_nxt = ret_r;
      S_OUT:  if (out_free) st_nxt = S_IDLE;
      S_LENS: begin
        poly_req.blk = 1'b1;
        poly_m = {txt_tot_r, aad_tot_r};
        st_nxt = S_PW;
      end
      S_TAG: begin
        poly_req.tag = 1'b1;
        st_nxt = S_TW;
      end
      S_TW: if (poly_done) st_nxt = S_T1;
      S_T1: if (out_free) st_nxt = S_T2;
      S_T2: begin
        if (out_free) begin
          poly_req.clear = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      ret_r     <= S_IDLE;
      keyrdy_r  <= 1'b0;
      phase_r   <= 1'b0;
      err_r     <= 1'b0;
      fill_r    <= '0;
      used_r    <= 7'd64;
      ctr_r     <= 32'd1;
      aad_tot_r <= '0;
      txt_tot_r <= '0;
      buf_r     <= '0;
      ov_r      <= 1'b0;
      i_r       <= '0;
    end else begin
      st_r <= st_nxt;
      if (load_out) ov_r <= 1'b1;
      else if (ov_r && out_ch.ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            i_r   <= '0;
            ct_r  <= '0;
          end
        end
        S_DISP: if (cmd_r.kind == CMD_ERR) err_r <= 1'b1;
        S_KEYW: if (cc_done) keyrdy_r <= 1'b1;
        S_ROUTE: begin
          if (cmd_r.kind == CMD_TEXT) begin
            phase_r <= 1'b1;
            ret_r   <= S_BYTE;
          end else begin
            ret_r <= S_LENS;
          end
        end
        S_BYTE: begin
          if (!bytes_left) begin
            if (is_text) txt_tot_r <= txt_tot_r + {60'd0, cmd_r.n};
            else aad_tot_r <= aad_tot_r + {60'd0, cmd_r.n};
          end else if (need_ks) begin
            ctr_r <= ctr_r + 32'd1;
          end else begin
            if (is_text) used_r <= used_r + 7'd1;
            ct_r[{i_r[2:0], 3'b000} +: 8] <= b;
            i_r <= i_r + 4'd1;
            if (fill_r == 4'd15) begin
              ret_r <= S_BYTE;
            end else begin
              buf_r  <= buf_w;
              fill_r <= fill_r + 4'd1;
            end
          end
        end
        S_KSW: if (cc_done) used_r <= '0;
        S_PW: begin
          if (poly_done) begin
            buf_r  <= '0;
            fill_r <= '0;
          end
        end
        S_OUT: begin
          if (out_free) begin
            odata_r  <= ct_r;
            okind_r  <= 1'b0;
            obytes_r <= cmd_r.n;
            olast_r  <= 1'b1;
            oerr_r   <= err_r;
          end
        end
        S_LENS: ret_r <= S_TAG;
        S_T1: begin
          if (out_free) begin
            odata_r  <= tag[63:0];
            okind_r  <= 1'b1;
            obytes_r <= 4'd8;
            olast_r  <= 1'b0;
            oerr_r   <= err_r;
          end
        end
        S_T2: begin
          if (out_free) begin
            odata_r   <= tag[127:64];
            okind_r   <= 1'b1;
            obytes_r  <= 4'd8;
            olast_r   <= 1'b1;
            oerr_r    <= err_r;
            aad_tot_r <= '0;
            txt_tot_r <= '0;
            phase_r   <= 1'b0;
            keyrdy_r  <= 1'b0;
            used_r    <= 7'd64;
            ctr_r     <= 32'd1;
            fill_r    <= '0;
            buf_r     <= '0;
          end
        end
        default: i_r <= i_r;
      endcase
    end
  end

endmodule

// ----- verif/chacha20_poly1305_seal_checker.sv -----
// Checker for the seal block: predicts every result item and compares it with the DUT.
`timescale 1ns / 1ps

module chacha20_poly1305_seal_checker import cpsl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  cpsl_in_if          in_mon,
  cpsl_out_if         out_mon,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  localparam logic [31:0] M26 = 32'h3ffffff;

  typedef struct packed {
    logic [63:0] data;
    logic        kind;
    logic [3:0]  nbytes;
    logic        last;
    logic        err;
  } seal_result_t;

  seal_result_t sealed_q[$];

  logic [63:0] key_nonce[6];
  logic [7:0]  ks[64];
  int unsigned ks_used;
  logic [31:0] blk_ctr;
  logic [31:0] r_limb[5];
  logic [31:0] pad_word[4];
  logic [31:0] acc[5];
  logic [7:0]  mblk[16];
  int unsigned mblk_fill;
  logic [63:0] aad_len, text_len;
  bit          text_phase, key_ready, err_flag;

  function automatic logic [31:0] rol32(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void qround(inout logic [31:0] x[16], input int a, b, c, d);
    x[a] = x[a] + x[b]; x[d] = rol32(x[d] ^ x[a], 16);
    x[c] = x[c] + x[d]; x[b] = rol32(x[b] ^ x[c], 12);
    x[a] = x[a] + x[b]; x[d] = rol32(x[d] ^ x[a], 8);
    x[c] = x[c] + x[d]; x[b] = rol32(x[b] ^ x[c], 7);
  endfunction

  function automatic void chacha_block(input logic [31:0] ctr, output logic [7:0] o[64]);
    logic [31:0] init[16], x[16], w;
    init[0] = 32'h61707865; init[1] = 32'h3320646e;
    init[2] = 32'h79622d32; init[3] = 32'h6b206574;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2 * i] = key_nonce[i][31:0];
      init[5 + 2 * i] = key_nonce[i][63:32];
    end
    init[12] = ctr;
    init[13] = key_nonce[4][31:0];
    init[14] = key_nonce[4][63:32];
    init[15] = key_nonce[5][31:0];
    x = init;
    for (int i = 0; i < 10; i++) begin
      qround(x, 0, 4, 8, 12); qround(x, 1, 5, 9, 13);
      qround(x, 2, 6, 10, 14); qround(x, 3, 7, 11, 15);
      qround(x, 0, 5, 10, 15); qround(x, 1, 6, 11, 12);
      qround(x, 2, 7, 8, 13); qround(x, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) begin
      w = x[i] + init[i];
      for (int j = 0; j < 4; j++) o[4 * i + j] = w[8 * j +: 8];
    end
  endfunction

  function automatic logic [63:0] mul(logic [31:0] a, logic [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  // One 16-byte Poly1305 block with the high bit set, in 26-bit limbs.
  function automatic void poly_block(input logic [7:0] m[16]);
    logic [31:0] s1, s2, s3, s4, c;
    logic [63:0] d0, d1, d2, d3, d4;
    s1 = r_limb[1] * 5; s2 = r_limb[2] * 5; s3 = r_limb[3] * 5; s4 = r_limb[4] * 5;
    acc[0] += {m[3], m[2], m[1], m[0]} & M26;
    acc[1] += ({m[6], m[5], m[4], m[3]} >> 2) & M26;
    acc[2] += ({m[9], m[8], m[7], m[6]} >> 4) & M26;
    acc[3] += ({m[12], m[11], m[10], m[9]} >> 6) & M26;
    acc[4] += ({m[15], m[14], m[13], m[12]} >> 8) | 32'h1000000;
    d0 = mul(acc[0], r_limb[0]) + mul(acc[1], s4) + mul(acc[2], s3) +
         mul(acc[3], s2) + mul(acc[4], s1);
    d1 = mul(acc[0], r_limb[1]) + mul(acc[1], r_limb[0]) + mul(acc[2], s4) +
         mul(acc[3], s3) + mul(acc[4], s2);
    d2 = mul(acc[0], r_limb[2]) + mul(acc[1], r_limb[1]) + mul(acc[2], r_limb[0]) +
         mul(acc[3], s4) + mul(acc[4], s3);
    d3 = mul(acc[0], r_limb[3]) + mul(acc[1], r_limb[2]) + mul(acc[2], r_limb[1]) +
         mul(acc[3], r_limb[0]) + mul(acc[4], s4);
    d4 = mul(acc[0], r_limb[4]) + mul(acc[1], r_limb[3]) + mul(acc[2], r_limb[2]) +
         mul(acc[3], r_limb[1]) + mul(acc[4], r_limb[0]);
    c = 32'(d0 >> 26); acc[0] = d0[31:0] & M26; d1 += c;
    c = 32'(d1 >> 26); acc[1] = d1[31:0] & M26; d2 += c;
    c = 32'(d2 >> 26); acc[2] = d2[31:0] & M26; d3 += c;
    c = 32'(d3 >> 26); acc[3] = d3[31:0] & M26; d4 += c;
    c = 32'(d4 >> 26); acc[4] = d4[31:0] & M26;
    acc[0] += c * 5;
    c = acc[0] >> 26; acc[0] &= M26; acc[1] += c;
  endfunction

  function automatic void flush_block();
    poly_block(mblk);
    foreach (mblk[i]) mblk[i] = '0;
    mblk_fill = 0;
  endfunction

  function automatic void absorb(logic [7:0] b);
    mblk[mblk_fill & 15] = b;
    mblk_fill++;
    if (mblk_fill >= 16) flush_block();
  endfunction

  function automatic void pad_section();
    if (mblk_fill != 0) flush_block();
  endfunction

  function automatic void derive_mac_key();
    logic [7:0] b[64];
    chacha_block(32'd0, b);
    r_limb[0] = {b[3], b[2], b[1], b[0]} & M26;
    r_limb[1] = ({b[6], b[5], b[4], b[3]} >> 2) & 32'h3ffff03;
    r_limb[2] = ({b[9], b[8], b[7], b[6]} >> 4) & 32'h3ffc0ff;
    r_limb[3] = ({b[12], b[11], b[10], b[9]} >> 6) & 32'h3f03fff;
    r_limb[4] = ({b[15], b[14], b[13], b[12]} >> 8) & 32'h00fffff;
    for (int i = 0; i < 4; i++)
      pad_word[i] = {b[19 + 4 * i], b[18 + 4 * i], b[17 + 4 * i], b[16 + 4 * i]};
    key_ready = 1;
  endfunction

  function automatic logic [7:0] next_key_byte();
    logic [7:0] b;
    if (ks_used >= 64) begin
      chacha_block(blk_ctr, ks);
      blk_ctr++;
      ks_used = 0;
    end
    b = ks[ks_used];
    ks_used++;
    return b;
  endfunction

  function automatic void clear_message();
    foreach (acc[i]) acc[i] = '0;
    foreach (mblk[i]) mblk[i] = '0;
    mblk_fill = 0;
    aad_len = '0;
    text_len = '0;
    text_phase = 0;
    key_ready = 0;
    ks_used = 64;
    blk_ctr = 32'd1;
  endfunction

  function automatic void compute_tag(output logic [63:0] lo, output logic [63:0] hi);
    logic [31:0] h0, h1, h2, h3, h4, c, g0, g1, g2, g3, g4, msk;
    logic [63:0] f;
    h0 = acc[0]; h1 = acc[1]; h2 = acc[2]; h3 = acc[3]; h4 = acc[4];
    c = h1 >> 26; h1 &= M26; h2 += c;
    c = h2 >> 26; h2 &= M26; h3 += c;
    c = h3 >> 26; h3 &= M26; h4 += c;
    c = h4 >> 26; h4 &= M26; h0 += c * 5;
    c = h0 >> 26; h0 &= M26; h1 += c;
    // Trial subtraction of 2^130 - 5; keep it when it does not go negative.
    g0 = h0 + 5; c = g0 >> 26; g0 &= M26;
    g1 = h1 + c; c = g1 >> 26; g1 &= M26;
    g2 = h2 + c; c = g2 >> 26; g2 &= M26;
    g3 = h3 + c; c = g3 >> 26; g3 &= M26;
    g4 = h4 + c - 32'h4000000;
    msk = (g4 >> 31) - 1;
    h0 = (h0 & ~msk) | (g0 & msk);
    h1 = (h1 & ~msk) | (g1 & msk);
    h2 = (h2 & ~msk) | (g2 & msk);
    h3 = (h3 & ~msk) | (g3 & msk);
    h4 = (h4 & ~msk) | (g4 & msk);
    g0 = h0 | (h1 << 26);
    g1 = (h1 >> 6) | (h2 << 20);
    g2 = (h2 >> 12) | (h3 << 14);
    g3 = (h3 >> 18) | (h4 << 8);
    f = 64'(g0) + pad_word[0]; g0 = f[31:0];
    f = 64'(g1) + pad_word[1] + (f >> 32); g1 = f[31:0];
    f = 64'(g2) + pad_word[2] + (f >> 32); g2 = f[31:0];
    f = 64'(g3) + pad_word[3] + (f >> 32); g3 = f[31:0];
    lo = {g1, g0};
    hi = {g3, g2};
  endfunction

  function automatic void seal_step(logic [1:0] op, logic [63:0] data, logic [3:0] cnt);
    int unsigned n;
    logic [7:0]  b;
    logic [63:0] ct, lo, hi;
    logic [7:0]  lens[16];
    n = (cnt > 8) ? 8 : cnt;
    case (op)
      OP_AAD: begin
        // An aad chunk after plaintext is dropped and raises the sticky flag.
        if (text_phase) err_flag = 1;
        else if (n != 0) begin
          if (!key_ready) derive_mac_key();
          for (int i = 0; i < n; i++) absorb(data[8 * i +: 8]);
          aad_len += n;
        end
      end
      OP_TEXT: begin
        if (n != 0) begin
          if (!key_ready) derive_mac_key();
          if (!text_phase) begin
            pad_section();
            text_phase = 1;
          end
          ct = '0;
          for (int i = 0; i < n; i++) begin
            b = data[8 * i +: 8] ^ next_key_byte();
            absorb(b);
            ct[8 * i +: 8] = b;
          end
          text_len += n;
          sealed_q.push_back('{ct, 1'b0, 4'(n), 1'b1, err_flag});
        end
      end
      OP_FIN: begin
        if (!key_ready) derive_mac_key();
        pad_section();
        for (int i = 0; i < 8; i++) begin
          lens[i] = aad_len[8 * i +: 8];
          lens[8 + i] = text_len[8 * i +: 8];
        end
        poly_block(lens);
        compute_tag(lo, hi);
        sealed_q.push_back('{lo, 1'b1, 4'd8, 1'b0, err_flag});
        sealed_q.push_back('{hi, 1'b1, 4'd8, 1'b1, err_flag});
        clear_message();
      end
      default: ;
    endcase
  endfunction

  function automatic void reset_model();
    foreach (key_nonce[i]) key_nonce[i] = '0;
    foreach (ks[i]) ks[i] = '0;
    foreach (r_limb[i]) r_limb[i] = '0;
    foreach (pad_word[i]) pad_word[i] = '0;
    err_flag = 0;
    clear_message();
    sealed_q.delete();
  endfunction

  function automatic void check_result(seal_result_t act);
    seal_result_t exp;
    if (sealed_q.size() == 0) begin
      $display("%0t: unexpected result item %h", $time, act);
      fail_count++;
      return;
    end
    exp = sealed_q.pop_front();
    if (exp.data !== act.data || exp.kind !== act.kind || exp.nbytes !== act.nbytes ||
        exp.last !== act.last || exp.err !== act.err) begin
      $display("%0t: mismatch expected data=%h kind=%0d bytes=%0d last=%0d err=%0d",
               $time, exp.data, exp.kind, exp.nbytes, exp.last, exp.err);
      $display("%0t:          actual   data=%h kind=%0d bytes=%0d last=%0d err=%0d",
               $time, act.data, act.kind, act.nbytes, act.last, act.err);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) reset_model();
    else begin
      if (cfg_we) begin
        if (cfg_index == REG_NONCE_HI) key_nonce[5] = {32'd0, cfg_wdata[31:0]};
        else if (cfg_index < REG_NONCE_HI) key_nonce[cfg_index] = cfg_wdata;
      end
      if (in_mon.valid && in_mon.ready)
        seal_step(in_mon.opcode, in_mon.data_word, in_mon.byte_count);
      if (out_mon.valid && out_mon.ready)
        check_result('{out_mon.data_out, out_mon.out_kind, out_mon.out_bytes,
                       out_mon.last_of_run, out_mon.order_error});
    end
    pending = sealed_q.size();
  end

endmodule

// ----- verif/chacha20_poly1305_seal_tb.sv -----
// Top of the seal testbench: clock, reset, stimulus, back-pressure and the verdict.
`timescale 1ns / 1ps

module chacha20_poly1305_seal_tb;
  import cpsl_pkg::*;

  // Opcode 3 is not used by the block, and index 6 lies beyond the register file.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] REG_NONE  = 3'd6;
  // Cycles without any accepted item before the run is declared hung.
  localparam int STALL_LIMIT = 20000;
  // Quiet time that covers a chunk still being absorbed when no result is due.
  localparam int SETTLE_CYCLES = 100;
  localparam int ITEMS_PER_PHASE = 165;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;
  int          fail_count, pending;
  int          send_idle, recv_stall;
  int          quiet_cycles;
  int          items_sent;

  always #2 clk = ~clk;

  cpsl_in_if  in_ch();
  cpsl_out_if out_ch();

  chacha20_poly1305_seal dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  chacha20_poly1305_seal_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // The receiver stalls at random, at the rate set by the current phase.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  // Watchdog: any accepted item on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one item, with random idle cycles ahead of it, and hold it until it is taken.
  task automatic send_item(input logic [1:0] op, input logic [63:0] d, input logic [3:0] n);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.data_word  <= d;
    in_ch.byte_count <= n;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op != OP_UNUSED && (op == OP_FIN || n != 0)) items_sent++;
  endtask

  // Wait until every predicted result has come out, then let the block settle.
  task automatic drain(input int extra);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Load all six key and nonce registers back to back; the block is idle here.
  task automatic load_key_nonce(input logic [63:0] k0, k1, k2, k3, nlo, nhi);
    logic [63:0] vals[6];
    vals = '{k0, k1, k2, k3, nlo, nhi};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    // A write to an index past the register file must leave everything unchanged.
    cfg_index <= REG_NONE + 3'($urandom_range(1));
    cfg_wdata <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // One message: aad chunks, plaintext chunks, finish. Some messages carry noise:
  // unused opcodes, empty or oversized chunks, and aad that arrives after plaintext.
  task automatic send_message(input int n_aad, input int n_text, input bit noisy);
    for (int i = 0; i < n_aad; i++) begin
      send_item(OP_AAD, rand64(), 4'($urandom_range(1, 8)));
      if (noisy && $urandom_range(3) == 0) send_item(OP_UNUSED, rand64(), 4'($urandom));
    end
    for (int i = 0; i < n_text; i++) begin
      send_item(OP_TEXT, rand64(), 4'($urandom_range(1, 8)));
      if (noisy) begin
        case ($urandom_range(5))
          0: send_item(OP_AAD, rand64(), 4'($urandom));
          1: send_item(OP_TEXT, rand64(), 4'd0);
          2: send_item(OP_TEXT, rand64(), 4'($urandom_range(9, 15)));
          3: send_item(OP_UNUSED, rand64(), 4'($urandom));
          default: ;
        endcase
      end
    end
    send_item(OP_FIN, rand64(), 4'($urandom));
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_AAD;
    in_ch.data_word  = '0;
    in_ch.byte_count = '0;
    out_ch.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_KEY0;
    cfg_wdata        = '0;
    quiet_cycles     = 0;
    items_sent       = 0;
    send_idle        = 0;
    recv_stall       = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first with the all-zero key and nonce left by reset.
    // A finish with nothing before it gives the tag of an empty message.
    send_item(OP_FIN, '0, 4'd0);
    // Extremes of data and length, followed by every plaintext chunk size.
    send_item(OP_AAD, '0, 4'd1);
    send_item(OP_AAD, '1, 4'd8);
    for (int n = 1; n <= 8; n++) send_item(OP_TEXT, (n[0] ? '1 : '0), 4'(n));
    send_item(OP_FIN, '1, 4'd15);
    drain(SETTLE_CYCLES);

    load_key_nonce('1, '1, '1, '1, '1, '1);
    // Ignored items: unused opcode and empty chunks; oversized counts act as eight.
    send_item(OP_UNUSED, '1, 4'd15);
    send_item(OP_AAD, '1, 4'd0);
    send_item(OP_TEXT, '1, 4'd0);
    send_item(OP_AAD, rand64(), 4'd15);
    send_item(OP_TEXT, rand64(), 4'd9);
    send_item(OP_TEXT, rand64(), 4'd12);
    // Aad after plaintext is dropped; the flag then sticks into the next message.
    send_item(OP_AAD, rand64(), 4'd5);
    send_item(OP_TEXT, rand64(), 4'd3);
    send_item(OP_FIN, '0, 4'd0);
    send_item(OP_TEXT, rand64(), 4'd8);
    send_item(OP_FIN, '0, 4'd0);
    drain(SETTLE_CYCLES);

    // Random part, in four phases of back-pressure with a new key and nonce each.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 66; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 66; end
        default: begin send_idle = 11; recv_stall = 11; end
      endcase
      if (phase == 2) load_key_nonce('0, '0, '0, '0, '0, '0);
      else load_key_nonce(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
      items_sent = 0;
      while (items_sent < ITEMS_PER_PHASE) begin
        // Most messages are short; one in eight has 9 to 20 plaintext chunks.
        send_message($urandom_range(0, 3),
                     ($urandom_range(7) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 6),
                     $urandom_range(9) == 0);
        // Now and then the sender holds off until every result is out.
        if ($urandom_range(7) == 0) drain(0);
      end
      drain(SETTLE_CYCLES);
    end

    drain(200);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/cpsl_pkg.sv
design/cpsl_if.sv
design/cpsl_front.sv
design/cpsl_chacha.sv
design/cpsl_poly.sv
design/cpsl_back.sv
design/chacha20_poly1305_seal.sv
verif/chacha20_poly1305_seal_checker.sv
verif/chacha20_poly1305_seal_tb.sv
